// File: src/plm_pkg.sv
// Package: shared types, mode codes and arithmetic helpers for face reconstruction.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

   // Reconstruction mode codes, 2 bits per field
   typedef enum logic [1:0] {
      MODE_UNDEF  = 2'd0,
      MODE_CONST  = 2'd1,
      MODE_MINMOD = 2'd2,
      MODE_MC     = 2'd3
   } mode_type;

   localparam int CellWidth = 32;
   localparam int WideWidth = 36;
   localparam int CfgWidth  = 16;
   localparam int ModeWidth = 2;

   typedef logic signed [CellWidth-1:0] cell_type;
   typedef logic signed [WideWidth-1:0] wide_type;

   // Magnitude of a wide value; operands never reach the most negative code
   function automatic wide_type mag(input wide_type v);
      mag = v[WideWidth-1] ? -v : v;
   endfunction

   // Zero unless both are strictly of one sign, else the one of least magnitude
   function automatic wide_type minmod2(input wide_type a, input wide_type b);
      logic same_sign;
      same_sign = ((a > 0) && (b > 0)) || ((a < 0) && (b < 0));
      if (!same_sign) begin
         minmod2 = '0;
      end else if (mag(a) < mag(b)) begin
         minmod2 = a;
      end else begin
         minmod2 = b;
      end
   endfunction

   // Doubled slope to half slope: magnitude rounded half away from zero
   function automatic wide_type half_offset(input wide_type t);
      wide_type r;
      r = (mag(t) + wide_type'(2)) >>> 2;
      half_offset = t[WideWidth-1] ? -r : r;
   endfunction

   // Clamp to the signed 32-bit range
   function automatic cell_type sat32(input wide_type v);
      if (v > wide_type'(64'sd2147483647)) begin
         sat32 = cell_type'(32'sh7FFFFFFF);
      end else if (v < wide_type'(-64'sd2147483648)) begin
         sat32 = cell_type'(32'sh80000000);
      end else begin
         sat32 = v[CellWidth-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: src/plm_limited_face_reconstruct.sv
// Top: limited piecewise-linear face states, one item per cycle unless results stall.
`timescale 1ns / 1ps
`default_nettype none

// Takes four consecutive cell values of one field (cells i-2 .. i+1) and returns the
// left and right states at face i-1/2, limited per field by the mode written from
// csr_wr_data bits [2f+1:2f] (1 constant, 2 minmod, 3 monotonized central, 0 gives
// status 1 with zero states). Values are signed Q15.16 and results saturate. The block
// is a two-register pipeline: an input register, then all slope and limiter logic in
// one pass, then the result register. It accepts one transfer per cycle while the
// result side does not stall. Each accepted input is captured in the input register and
// its result in the result register, which holds it while the result side stalls.
// A field_number at or above FIELDS reports an undefined mode. Write the mode
// register only while no item is in flight.
module plm_limited_face_reconstruct #(
   parameter int FIELDS = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_field_number,
   input  wire  [31:0] req_cell_minus_two,
   input  wire  [31:0] req_cell_minus_one,
   input  wire  [31:0] req_cell_center,
   input  wire  [31:0] req_cell_plus_one,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_left_state,
   output logic [31:0] rsp_right_state,
   output logic        rsp_status,
   input  wire         csr_wr_en,
   input  wire  [15:0] csr_wr_data
);

   // Mode register
   logic [plm_pkg::CfgWidth-1:0] slope_modes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_modes_ff <= 16'h5555;
      end else if (csr_wr_en) begin
         slope_modes_ff <= csr_wr_data;
      end
   end

   // Input stage
   logic              s1_valid_ff;
   logic [2:0]        s1_field_ff;
   plm_pkg::cell_type s1_um2_ff, s1_um1_ff, s1_u0_ff, s1_up1_ff;
   logic              s1_advance;

   assign s1_advance = !rsp_valid || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Hold payload until the stage moves on
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_field_ff <= req_field_number;
         s1_um2_ff   <= req_cell_minus_two;
         s1_um1_ff   <= req_cell_minus_one;
         s1_u0_ff    <= req_cell_center;
         s1_up1_ff   <= req_cell_plus_one;
      end
   end

   // Mode lookup for the held field
   plm_pkg::mode_type mode;
   logic [3:0]        mode_bit;

   assign mode_bit = {s1_field_ff, 1'b0};

   always_comb begin
      if (32'(s1_field_ff) < FIELDS) begin
         mode = plm_pkg::mode_type'(slope_modes_ff[mode_bit +: plm_pkg::ModeWidth]);
      end else begin
         mode = plm_pkg::MODE_UNDEF;
      end
   end

   // Differences, widened so the scaled forms stay exact
   plm_pkg::wide_type um2_w, um1_w, u0_w, up1_w;
   plm_pkg::wide_type d_left, d_mid, d_right, c_left, c_right;

   assign um2_w   = plm_pkg::WideWidth'(s1_um2_ff);
   assign um1_w   = plm_pkg::WideWidth'(s1_um1_ff);
   assign u0_w    = plm_pkg::WideWidth'(s1_u0_ff);
   assign up1_w   = plm_pkg::WideWidth'(s1_up1_ff);
   assign d_left  = um1_w - um2_w;
   assign d_mid   = u0_w - um1_w;
   assign d_right = up1_w - u0_w;
   assign c_left  = u0_w - um2_w;
   assign c_right = up1_w - um1_w;

   // Limited doubled slopes and face states
   plm_pkg::wide_type slope_l, slope_r;
   plm_pkg::cell_type left_in, right_in;
   logic              status_in;

   always_comb begin
      slope_l   = '0;
      slope_r   = '0;
      status_in = 1'b0;
      case (mode)
         plm_pkg::MODE_CONST: begin
            slope_l = '0;
            slope_r = '0;
         end
         plm_pkg::MODE_MINMOD: begin
            slope_l = plm_pkg::minmod2(d_left <<< 1, d_mid <<< 1);
            slope_r = plm_pkg::minmod2(d_mid <<< 1, d_right <<< 1);
         end
         plm_pkg::MODE_MC: begin
            slope_l = plm_pkg::minmod2(c_left,
                         plm_pkg::minmod2(d_mid <<< 2, d_left <<< 2));
            slope_r = plm_pkg::minmod2(c_right,
                         plm_pkg::minmod2(d_right <<< 2, d_mid <<< 2));
         end
         default: begin
            status_in = 1'b1;
         end
      endcase
      if (status_in) begin
         left_in  = '0;
         right_in = '0;
      end else begin
         left_in  = plm_pkg::sat32(um1_w + plm_pkg::half_offset(slope_l));
         right_in = plm_pkg::sat32(u0_w - plm_pkg::half_offset(slope_r));
      end
   end

   // Result register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_left_state  <= left_in;
         rsp_right_state <= right_in;
         rsp_status      <= status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An undefined mode never carries nonzero states
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_left_state == '0 && rsp_right_state == '0)
      else $error("undefined mode result with nonzero state");

   // Reset empties the pipeline
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   // An accepted transfer always lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted transfer lost");

   // A stalled result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_state)
         && $stable(rsp_right_state) && $stable(rsp_status))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: dv/tb_plm_limited_face_reconstruct.sv
// Testbench for plm_limited_face_reconstruct: random and directed stencils, predicted states.
`timescale 1ns / 1ps

module tb_plm_limited_face_reconstruct;

   localparam int FieldCount = 8;
   localparam int ItemsPerPhase = 150;
   localparam int PhaseCount = 8;
   localparam int HoldCycles = 80;
   localparam int HoldItems = 24;
   localparam int DrainCycles = 6;
   localparam int TimeLimitNs = 8_000_000;

   // One stencil as offered on the request side
   typedef struct packed {
      logic [2:0]  field;
      logic [31:0] minus_two;
      logic [31:0] minus_one;
      logic [31:0] center;
      logic [31:0] plus_one;
   } stencil_type;

   // One face result as seen on the response side
   typedef struct packed {
      logic [31:0] left_state;
      logic [31:0] right_state;
      logic        status;
   } face_states_type;

   // Predict face states for each accepted stencil and check returned results in order
   class face_scoreboard;
      localparam logic [15:0] ResetModes = 16'h5555;
      localparam longint CellMax = 64'sh7FFFFFFF;
      localparam longint CellMin = -64'sh80000000;
      localparam int PrintLimit = 100;

      logic [15:0]     modes;
      face_states_type expected_q[$];
      int unsigned     mismatches;

      function new();
         modes = ResetModes;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Zero unless both are strictly of one sign, else the smaller in magnitude
      function longint limit_pair(longint a, longint b);
         if (!((a > 0 && b > 0) || (a < 0 && b < 0))) begin
            return 0;
         end
         return ((a < 0 ? -a : a) < (b < 0 ? -b : b)) ? a : b;
      endfunction

      // Doubled slope to half-slope offset, magnitude rounded half away from zero
      function longint quarter_offset(longint t);
         longint r;
         r = ((t < 0 ? -t : t) + 2) / 4;
         return t < 0 ? -r : r;
      endfunction

      function logic [31:0] clamp_cell(longint v);
         if (v > CellMax) begin
            return CellMax[31:0];
         end
         if (v < CellMin) begin
            return CellMin[31:0];
         end
         return v[31:0];
      endfunction

      function void note_request(stencil_type s);
         longint            um2, um1, u0, up1, tl, tr;
         plm_pkg::mode_type mode;
         face_states_type   e;
         um2 = $signed(s.minus_two);
         um1 = $signed(s.minus_one);
         u0  = $signed(s.center);
         up1 = $signed(s.plus_one);
         mode = plm_pkg::mode_type'(modes[2*s.field +: 2]);
         if (s.field >= FieldCount) begin
            mode = plm_pkg::MODE_UNDEF;
         end
         tl = 0;
         tr = 0;
         e = '0;
         case (mode)
            plm_pkg::MODE_CONST: begin
               // states are the cell values themselves
            end
            plm_pkg::MODE_MINMOD: begin
               tl = limit_pair(2 * (um1 - um2), 2 * (u0 - um1));
               tr = limit_pair(2 * (u0 - um1), 2 * (up1 - u0));
            end
            plm_pkg::MODE_MC: begin
               tl = limit_pair(u0 - um2, limit_pair(4 * (u0 - um1), 4 * (um1 - um2)));
               tr = limit_pair(up1 - um1, limit_pair(4 * (up1 - u0), 4 * (u0 - um1)));
            end
            default: begin
               e.status = 1'b1;
            end
         endcase
         if (!e.status) begin
            e.left_state  = clamp_cell(um1 + quarter_offset(tl));
            e.right_state = clamp_cell(u0 - quarter_offset(tr));
         end
         expected_q.push_back(e);
      endfunction

      task report_mismatch(string msg);
         // keep the log short when everything goes wrong
         if (mismatches < PrintLimit) begin
            $display("[%0t] MISMATCH %s", $time, msg);
         end
         mismatches++;
      endtask

      task check_response(logic [31:0] left, logic [31:0] right, logic status);
         face_states_type e;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result left %h right %h status %b",
                                      left, right, status));
            return;
         end
         e = expected_q.pop_front();
         if (left !== e.left_state) begin
            report_mismatch($sformatf("left_state %h, expected %h", left, e.left_state));
         end
         if (right !== e.right_state) begin
            report_mismatch($sformatf("right_state %h, expected %h", right, e.right_state));
         end
         if (status !== e.status) begin
            report_mismatch($sformatf("status %b, expected %b", status, e.status));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   stencil_type offered;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_left_state;
   logic [31:0] rsp_right_state;
   logic        rsp_status;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   bit tx_idle_en;
   bit rx_idle_en;
   bit hold_off_req;
   bit hold_active;

   face_scoreboard sb = new();

   plm_limited_face_reconstruct #(
      .FIELDS(FieldCount)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_field_number   (offered.field),
      .req_cell_minus_two (offered.minus_two),
      .req_cell_minus_one (offered.minus_one),
      .req_cell_center    (offered.center),
      .req_cell_plus_one  (offered.plus_one),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_state     (rsp_left_state),
      .rsp_right_state    (rsp_right_state),
      .rsp_status         (rsp_status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #(TimeLimitNs);
      $display("Simulation FAILED");
      $finish;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(bit enabled);
      int unsigned r;
      if (!enabled) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Build a stencil: mostly smooth or steady profiles, some noise and edge values
   function automatic stencil_type build_stencil();
      stencil_type s;
      logic [31:0] v [4];
      logic [31:0] step;
      int unsigned span;
      int unsigned kind;
      bit          falling;
      kind = $urandom_range(0, 99);
      span = 32'd1 << $urandom_range(0, 24);
      falling = 1'($urandom_range(0, 1));
      for (int k = 0; k < 4; k++) begin
         if (kind >= 85) begin
            case ($urandom_range(0, 4))
               0: v[k] = 32'h7FFF_FFFF;
               1: v[k] = 32'h8000_0000;
               2: v[k] = 32'h0000_0000;
               3: v[k] = 32'h0000_0001;
               default: v[k] = 32'hFFFF_FFFF;
            endcase
         end else if (k == 0 || kind >= 65) begin
            v[k] = $urandom;
         end else if (kind < 45) begin
            step = $urandom_range(0, span);
            v[k] = $urandom_range(0, 1) ? v[k-1] + step : v[k-1] - step;
         end else begin
            step = span + $urandom_range(0, span / 4);
            v[k] = falling ? v[k-1] - step : v[k-1] + step;
         end
      end
      s.field = 3'($urandom_range(0, FieldCount - 1));
      s.minus_two = v[0];
      s.minus_one = v[1];
      s.center = v[2];
      s.plus_one = v[3];
      return s;
   endfunction

   // Offer one stencil after a random gap and hold it until the transfer
   task automatic send_item(stencil_type s);
      int unsigned gap;
      gap = pick_gap(tx_idle_en);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      offered <= s;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_cells(logic [2:0] f, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c, logic [31:0] d);
      send_item('{f, a, b, c, d});
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      // step one edge first so the last transfer is already noted
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write the mode register; only called with nothing in flight
   task automatic write_modes(logic [15:0] value);
      sb.modes = value;
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Sample both channels at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(offered);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_left_state, rsp_right_state, rsp_status);
         end
      end
   end

   // Response side: alternate ready runs and stalls, or hold off on request
   initial begin
      bit ready_turn;
      int unsigned span;
      rsp_ready = 1'b0;
      ready_turn = 1'b1;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off_req = 1'b0;
            hold_active = 1'b0;
         end else if (ready_turn || !rx_idle_en) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            ready_turn = 1'b0;
         end else begin
            rsp_ready <= 1'b0;
            span = pick_gap(1'b1);
            repeat (span == 0 ? 1 : span) @(posedge clock);
            ready_turn = 1'b1;
         end
      end
   end

   // Stimulus
   initial begin
      logic [15:0] fixed_modes [5];
      logic [31:0] edge_sets [7][4];
      logic [15:0] cfg;
      fixed_modes = '{16'hFFFF, 16'hAAAA, 16'h0000, 16'h5555, 16'h1B1B};
      edge_sets = '{
         '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003},
         '{32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000},
         '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
         '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
         '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
         '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
         '{32'h8000_0000, 32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF}
      };
      reset = 1'b1;
      req_valid = 1'b0;
      offered = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      hold_off_req = 1'b0;
      hold_active = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Modes after reset: every field constant
      send_cells(3'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_8000, 32'h0004_0000);
      send_cells(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      settle();

      // Fields cycle undefined, constant, minmod, MC
      write_modes(16'hE4E4);
      for (int f = 0; f < FieldCount; f++) begin
         send_cells(f[2:0], 32'h0001_0000, 32'h0002_0000, 32'h0003_8000, 32'h0004_0000);
      end
      for (int f = 2; f < 4; f++) begin
         for (int k = 0; k < 7; k++) begin
            send_cells(f[2:0], edge_sets[k][0], edge_sets[k][1],
                       edge_sets[k][2], edge_sets[k][3]);
         end
      end
      send_cells(3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      settle();

      // Random phases, each under its own mode setting
      for (int phase = 0; phase < PhaseCount; phase++) begin
         cfg = (phase < 5) ? fixed_modes[phase] : 16'($urandom_range(0, 16'hFFFF));
         write_modes(cfg);
         tx_idle_en = (phase % 3) != 0;
         rx_idle_en = (phase % 3) != 0;
         if (phase == 1) begin
            // back up the pipeline behind a stalled receiver
            hold_off_req = 1'b1;
            tx_idle_en = 1'b0;
            wait (hold_active);
            repeat (HoldItems) send_item(build_stencil());
            tx_idle_en = 1'b1;
         end
         repeat (ItemsPerPhase) send_item(build_stencil());
         settle();
      end

      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
src/plm_pkg.sv
src/plm_limited_face_reconstruct.sv
dv/tb_plm_limited_face_reconstruct.sv
